/* hw/rtl/vau_pkg.sv */
package vau_pkg;

	// Default component format: signed Q16.16.
	localparam int COMP_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Largest distance that the 31-bit distance port can show.
	localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

	// Operation codes of an item.
	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_ADDS = 4'd4,
		OP_SUBS = 4'd5,
		OP_MULS = 4'd6,
		OP_DIVS = 4'd7,
		OP_CMP  = 4'd8,
		OP_DIST = 4'd9,
		OP_NORM = 4'd10
	} op_e;

	// Multiplier operand width: at least 32 bits and even, so that it splits in halves.
	function automatic int mul_width_f(input int w);
		int m;
		m = (w > 32) ? w : 32;
		return ((m + 1) >> 1) << 1;
	endfunction

	// Cycles from an accepted item to its result strobe.
	function automatic int latency_f(input int w, input int f);
		return 6 + (mul_width_f(w) + 1) + (w + f);
	endfunction

endpackage

/* hw/rtl/vau_mul.sv */
module vau_mul #(
	parameter int MW = 32
) (
	input  logic              clk,
	input  logic [MW-1:0]     a,
	input  logic [MW-1:0]     b,
	output logic [2*MW-1:0]   p
);
	localparam int H  = MW / 2;
	localparam int PW = 2 * MW;

	logic [2*H-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [PW-1:0]  p_s2;

	// First stage: four half-width partial products.
	always_ff @(posedge clk) begin
		ll_s1 <= a[H-1:0] * b[H-1:0];
		lh_s1 <= a[H-1:0] * b[MW-1:H];
		hl_s1 <= a[MW-1:H] * b[H-1:0];
		hh_s1 <= a[MW-1:H] * b[MW-1:H];
	end

	// Second stage: combine the partial products into the full product.
	always_ff @(posedge clk) begin
		p_s2 <= {hh_s1, ll_s1} + ((PW'(lh_s1) + PW'(hl_s1)) << H);
	end

	assign p = p_s2;

endmodule

/* hw/rtl/vau_sqrt.sv */
module vau_sqrt #(
	parameter int QW = 66
) (
	input  logic              clk,
	input  logic [QW-1:0]     rad,
	output logic [QW/2-1:0]   root
);
	localparam int NQ = QW / 2;
	localparam int RW = NQ + 2;

	logic [RW-1:0] rem_q  [NQ];
	logic [NQ-1:0] root_q [NQ];
	logic [QW-1:0] rad_q  [NQ];
	logic [RW-1:0] rem_d  [NQ];
	logic [NQ-1:0] root_d [NQ];
	logic [QW-1:0] rad_d  [NQ];

	// One result bit per stage: bring down two radicand bits and try the next root bit.
	for (genvar j = 0; j < NQ; j++) begin : g_stage
		logic [RW-1:0] r_in;
		logic [NQ-1:0] o_in;
		logic [QW-1:0] d_in;
		logic [RW+1:0] t;
		logic [RW+1:0] trial;
		logic          ge;
		if (j == 0) begin : g_first
			assign r_in = '0;
			assign o_in = '0;
			assign d_in = rad;
		end else begin : g_next
			assign r_in = rem_q[j-1];
			assign o_in = root_q[j-1];
			assign d_in = rad_q[j-1];
		end
		assign t         = {r_in, d_in[QW-1:QW-2]};
		assign trial     = (RW+2)'({o_in, 2'b01});
		assign ge        = (t >= trial);
		assign rem_d[j]  = ge ? RW'(t - trial) : RW'(t);
		assign root_d[j] = {o_in[NQ-2:0], ge};
		assign rad_d[j]  = d_in << 2;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NQ; j++) begin
			rem_q[j]  <= rem_d[j];
			root_q[j] <= root_d[j];
			rad_q[j]  <= rad_d[j];
		end
	end

	assign root = root_q[NQ-1];

endmodule

/* hw/rtl/vau_div.sv */
module vau_div #(
	parameter int NB = 48,
	parameter int DW = 33
) (
	input  logic          clk,
	input  logic [NB-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NB-1:0] quot
);
	logic [DW-1:0] rem_q [NB];
	logic [DW-1:0] den_q [NB];
	logic [NB-1:0] nq_q  [NB];
	logic [DW-1:0] rem_d [NB];
	logic [NB-1:0] nq_d  [NB];

	// Restoring division, one quotient bit per stage. The numerator shifts out at the
	// top of nq while the quotient bits shift in at the bottom.
	for (genvar j = 0; j < NB; j++) begin : g_stage
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [NB-1:0] n_in;
		logic [DW:0]   t;
		logic          ge;
		if (j == 0) begin : g_first
			assign r_in = '0;
			assign d_in = den;
			assign n_in = num;
		end else begin : g_next
			assign r_in = rem_q[j-1];
			assign d_in = den_q[j-1];
			assign n_in = nq_q[j-1];
		end
		assign t        = {r_in, n_in[NB-1]};
		assign ge       = (t >= {1'b0, d_in});
		assign rem_d[j] = ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
		assign nq_d[j]  = {n_in[NB-2:0], ge};
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NB; j++) begin
			rem_q[j] <= rem_d[j];
			nq_q[j]  <= nq_d[j];
			den_q[j] <= (j == 0) ? den : den_q[(j == 0) ? 0 : j-1];
		end
	end

	assign quot = nq_q[NB-1];

endmodule

/* hw/rtl/vau_lane.sv */
module vau_lane #(
	parameter int COMP_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  vau_pkg::op_e                        op,
	input  logic [COMP_WIDTH-1:0]               a,
	input  logic [COMP_WIDTH-1:0]               b,
	output logic [2*vau_pkg::mul_width_f(COMP_WIDTH)-1:0] prod,
	output logic                                dbig,
	input  logic [vau_pkg::mul_width_f(COMP_WIDTH):0]     len,
	output logic [COMP_WIDTH-1:0]               res,
	output logic                                res_fault
);
	import vau_pkg::*;

	localparam int W    = COMP_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int MW   = mul_width_f(W);
	localparam int PW   = 2 * MW;
	localparam int DW   = MW + 1;
	localparam int NQ   = MW + 1;
	localparam int NB   = W + F;
	localparam int SMW  = (PW > NB) ? PW : NB;
	localparam int XW   = (W + 1 > 32) ? W + 1 : 32;
	localparam int DSTG = 4 + NQ;
	localparam int CEND = DSTG + NB;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		op_e          op;
		logic [W-1:0] res;
		logic         flt;
		logic         aneg;
		logic         qneg;
		logic [W-1:0] amag;
		logic [W-1:0] bmag;
		logic         bzero;
		logic         lenz;
	} ctx_t;

	// Clamp a magnitude with a sign to the component range; the top bit reports a clamp.
	function automatic logic [W:0] sat_f(input logic neg, input logic [SMW-1:0] mag);
		logic [SMW-1:0] lim;
		logic [W-1:0]   m;
		logic           ovf;
		lim = neg ? SMW'(MINV) : SMW'(MAXV);
		ovf = (mag > lim);
		m   = ovf ? lim[W-1:0] : mag[W-1:0];
		return {ovf, neg ? (W'(0) - m) : m};
	endfunction

	logic [W:0]    a_sx, b_sx, as_sum, diff, dmag;
	logic          as_ovf;
	logic [W-1:0]  as_res, amag, bmag;
	logic [MW-1:0] ma, mb;
	ctx_t          ctx_in;
	ctx_t          ctx_q [2:CEND];
	ctx_t          ctx_mul, ctx_len;
	logic [W:0]    mul_sat;
	logic [NB-1:0] num, quot;
	logic [DW-1:0] den;
	logic [W:0]    q_sat;
	ctx_t          cf;
	logic [W-1:0]  fin_res;
	logic          fin_flt;
	logic [W-1:0]  res_q;
	logic          flt_q;
	logic          dbig_q, dbig_s3;

	// Entry: saturating add or subtract, magnitudes, and the multiplier operands.
	always_comb begin
		a_sx   = {a[W-1], a};
		b_sx   = {b[W-1], b};
		as_sum = (op == OP_SUB || op == OP_SUBS) ? (a_sx - b_sx) : (a_sx + b_sx);
		as_ovf = as_sum[W] ^ as_sum[W-1];
		as_res = as_ovf ? (as_sum[W] ? MINV : MAXV) : as_sum[W-1:0];
		amag   = a[W-1] ? (W'(0) - a) : a;
		bmag   = b[W-1] ? (W'(0) - b) : b;
		diff   = a_sx - b_sx;
		dmag   = diff[W] ? ((W+1)'(0) - diff) : diff;
		case (op)
			OP_DIST: begin
				ma = MW'(dmag);
				mb = MW'(dmag);
			end
			OP_NORM: begin
				ma = MW'(amag);
				mb = MW'(amag);
			end
			default: begin
				ma = MW'(amag);
				mb = MW'(bmag);
			end
		endcase
		ctx_in.op    = op;
		ctx_in.res   = as_res;
		ctx_in.flt   = as_ovf;
		ctx_in.aneg  = a[W-1];
		ctx_in.qneg  = a[W-1] ^ b[W-1];
		ctx_in.amag  = amag;
		ctx_in.bmag  = bmag;
		ctx_in.bzero = (b == '0);
		ctx_in.lenz  = 1'b0;
	end

	vau_mul #(.MW(MW)) u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.p   (prod)
	);

	// Distance operands too large for the 31-bit result are flagged, aligned with the product.
	always_ff @(posedge clk) begin
		dbig_q  <= (XW'(dmag) > XW'(DIST_MAX));
		dbig_s3 <= dbig_q;
	end
	assign dbig = dbig_s3;

	assign mul_sat = sat_f(ctx_q[3].qneg, SMW'(prod[PW-1:F]));

	// Context entries that pick up the saturated product and the zero-length mark.
	always_comb begin
		ctx_mul = ctx_q[3];
		if (ctx_q[3].op == OP_MUL || ctx_q[3].op == OP_MULS) begin
			ctx_mul.res = mul_sat[W-1:0];
			ctx_mul.flt = mul_sat[W];
		end
		ctx_len      = ctx_q[DSTG];
		ctx_len.lenz = (len == '0);
	end

	// Context travels alongside the multiplier, the square root and the divider.
	always_ff @(posedge clk) begin
		ctx_q[2] <= ctx_in;
		for (int k = 3; k <= CEND; k++) begin
			if (k == 4) begin
				ctx_q[k] <= ctx_mul;
			end else if (k == DSTG + 1) begin
				ctx_q[k] <= ctx_len;
			end else begin
				ctx_q[k] <= ctx_q[k-1];
			end
		end
	end

	// Divider input: the scalar or component divisor, or the length for normalization.
	assign num = {ctx_q[DSTG].amag, {F{1'b0}}};
	assign den = (ctx_q[DSTG].op == OP_NORM) ? len : DW'(ctx_q[DSTG].bmag);

	vau_div #(.NB(NB), .DW(DW)) u_div (
		.clk  (clk),
		.num  (num),
		.den  (den),
		.quot (quot)
	);

	// Final selection per operation.
	always_comb begin
		cf      = ctx_q[CEND];
		fin_res = '0;
		fin_flt = 1'b0;
		case (cf.op)
			OP_NORM: q_sat = sat_f(cf.aneg, SMW'(quot));
			default: q_sat = sat_f(cf.qneg, SMW'(quot));
		endcase
		case (cf.op) inside
			OP_ADD, OP_SUB, OP_MUL, OP_ADDS, OP_SUBS, OP_MULS: begin
				fin_res = cf.res;
				fin_flt = cf.flt;
			end
			OP_DIV, OP_DIVS: begin
				if (cf.bzero) begin
					fin_flt = 1'b1;
					fin_res = (cf.amag == '0) ? '0 : (cf.aneg ? MINV : MAXV);
				end else begin
					fin_res = q_sat[W-1:0];
					fin_flt = q_sat[W];
				end
			end
			OP_NORM: begin
				if (!cf.lenz) begin
					fin_res = q_sat[W-1:0];
					fin_flt = q_sat[W];
				end
			end
			default: begin
				fin_res = '0;
				fin_flt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_q <= fin_res;
		flt_q <= fin_flt;
	end

	assign res       = res_q;
	assign res_fault = flt_q;

endmodule

/* hw/rtl/vector3_arithmetic_unit_core.sv */
// Channel   Handshake        Ports
// --------  ---------------  ----------------------------------------------------
// item in   start && !busy   operation, a_x, a_y, a_z, b_x, b_y, b_z
// result    done (1 cycle)   r_x, r_y, r_z, distance, equal_flag, fault
//
// One item is accepted every cycle; busy stays low.
// Each result passes the input register, the multiplier, the sum register, the square-root
// and divider stages, and the lane and output registers (default format Q16.16).
// The receiver cannot stall: done lasts one cycle and results are not held afterwards.
// Reset clears only the valid pipeline; no item in flight survives it.
module vector3_arithmetic_unit_core #(
	parameter int COMP_WIDTH = vau_pkg::COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = vau_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	output logic                         done,
	input  logic [3:0]                   operation,
	input  logic signed [COMP_WIDTH-1:0] a_x,
	input  logic signed [COMP_WIDTH-1:0] a_y,
	input  logic signed [COMP_WIDTH-1:0] a_z,
	input  logic signed [COMP_WIDTH-1:0] b_x,
	input  logic signed [COMP_WIDTH-1:0] b_y,
	input  logic signed [COMP_WIDTH-1:0] b_z,
	output logic signed [COMP_WIDTH-1:0] r_x,
	output logic signed [COMP_WIDTH-1:0] r_y,
	output logic signed [COMP_WIDTH-1:0] r_z,
	output logic [30:0]                  distance,
	output logic                         equal_flag,
	output logic                         fault
);
	import vau_pkg::*;

	localparam int W    = COMP_WIDTH;
	localparam int MW   = mul_width_f(W);
	localparam int PW   = 2 * MW;
	localparam int QW   = PW + 2;
	localparam int NQ   = MW + 1;
	localparam int NB   = W + FRAC_BITS;
	localparam int DSTG = 4 + NQ;
	localparam int IEND = DSTG + NB + 1;
	localparam int LAT  = latency_f(W, FRAC_BITS);

	typedef struct packed {
		op_e         op;
		logic        eq;
		logic        big;
		logic [30:0] dval;
		logic        dflt;
	} info_t;

	logic          accept;
	logic          scalar;
	op_e           op_s1;
	logic [W-1:0]  a_s1 [3];
	logic [W-1:0]  b_s1 [3];
	info_t         info_in;
	info_t         info_q [1:IEND];
	info_t         info_big, info_dst;
	logic [LAT:1]  vld_q;
	logic [PW-1:0] prod [3];
	logic          dbig [3];
	logic [NQ-1:0] len;
	logic [QW-1:0] sum_s4;
	logic [W-1:0]  lres [3];
	logic          lflt [3];
	info_t         ie;
	logic [W-1:0]  rx_q, ry_q, rz_q;
	logic [30:0]   dist_q;
	logic          eq_q, flt_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign scalar = (operation == OP_ADDS) || (operation == OP_SUBS) ||
	                (operation == OP_MULS) || (operation == OP_DIVS);

	always_comb begin
		info_in.op   = op_e'(operation);
		info_in.eq   = (a_x == b_x) && (a_y == b_y) && (a_z == b_z);
		info_in.big  = 1'b0;
		info_in.dval = '0;
		info_in.dflt = 1'b0;
	end

	// Valid bits follow each item down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-1:1], accept};
		end
	end

	// Input register; the scalar forms broadcast b_x to every lane.
	always_ff @(posedge clk) begin
		op_s1   <= op_e'(operation);
		a_s1[0] <= a_x;
		a_s1[1] <= a_y;
		a_s1[2] <= a_z;
		b_s1[0] <= b_x;
		b_s1[1] <= scalar ? b_x : b_y;
		b_s1[2] <= scalar ? b_x : b_z;
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		vau_lane #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
			.clk       (clk),
			.op        (op_s1),
			.a         (a_s1[i]),
			.b         (b_s1[i]),
			.prod      (prod[i]),
			.dbig      (dbig[i]),
			.len       (len),
			.res       (lres[i]),
			.res_fault (lflt[i])
		);
	end

	// Merge: sum of the three lane products (the squares for distance and normalization) feeds one shared square root.
	always_ff @(posedge clk) begin
		sum_s4 <= QW'(prod[0]) + QW'(prod[1]) + QW'(prod[2]);
	end

	vau_sqrt #(.QW(QW)) u_sqrt (
		.clk  (clk),
		.rad  (sum_s4),
		.root (len)
	);

	// Entries that pick up the oversize mark and, once the root is out, the distance.
	always_comb begin
		info_big     = info_q[3];
		info_big.big = dbig[0] | dbig[1] | dbig[2];
		info_dst     = info_q[DSTG];
		if (info_q[DSTG].big || (len > NQ'(DIST_MAX))) begin
			info_dst.dval = DIST_MAX;
			info_dst.dflt = 1'b1;
		end else begin
			info_dst.dval = len[30:0];
			info_dst.dflt = 1'b0;
		end
	end

	// Per-item information that bypasses the lanes.
	always_ff @(posedge clk) begin
		info_q[1] <= info_in;
		for (int k = 2; k <= IEND; k++) begin
			if (k == 4) begin
				info_q[k] <= info_big;
			end else if (k == DSTG + 1) begin
				info_q[k] <= info_dst;
			end else begin
				info_q[k] <= info_q[k-1];
			end
		end
	end

	// Output register: lane results and the merged flags.
	assign ie = info_q[IEND];
	always_ff @(posedge clk) begin
		rx_q   <= lres[0];
		ry_q   <= lres[1];
		rz_q   <= lres[2];
		dist_q <= (ie.op == OP_DIST) ? ie.dval : '0;
		eq_q   <= (ie.op == OP_CMP) ? ie.eq : 1'b0;
		flt_q  <= lflt[0] | lflt[1] | lflt[2] | ((ie.op == OP_DIST) && ie.dflt);
	end

	assign done       = vld_q[LAT];
	assign r_x        = rx_q;
	assign r_y        = ry_q;
	assign r_z        = rz_q;
	assign distance   = dist_q;
	assign equal_flag = eq_q;
	assign fault      = flt_q;

endmodule

/* hw/rtl/vau_checker.sv */
module vau_checker #(
	parameter int COMP_WIDTH = vau_pkg::COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = vau_pkg::FRAC_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [COMP_WIDTH-1:0] r_x,
	input logic [COMP_WIDTH-1:0] r_y,
	input logic [COMP_WIDTH-1:0] r_z,
	input logic [30:0]           distance,
	input logic                  equal_flag,
	input logic                  fault
);
	import vau_pkg::*;

	localparam int LAT = latency_f(COMP_WIDTH, FRAC_BITS);

	// The pipeline always takes an item.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every result belongs to an item started a fixed latency earlier.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching item");

	// An equal compare result carries no vector, no distance and no fault.
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && equal_flag |-> r_x == '0 && r_y == '0 && r_z == '0 && !fault && distance == '0)
		else $error("compare result not clean");

	// A nonzero distance result carries no vector and no equality.
	a_dist_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && distance != '0 |-> r_x == '0 && r_y == '0 && r_z == '0 && !equal_flag)
		else $error("distance result not clean");

endmodule

bind vector3_arithmetic_unit_core vau_checker #(
	.COMP_WIDTH (COMP_WIDTH),
	.FRAC_BITS  (FRAC_BITS)
) u_vau_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.r_x        (r_x),
	.r_y        (r_y),
	.r_z        (r_z),
	.distance   (distance),
	.equal_flag (equal_flag),
	.fault      (fault)
);

/* bench/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vau_pkg::*;

	localparam int LATENCY = latency_f(COMP_WIDTH_DEF, FRAC_BITS_DEF);
	localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;

	typedef logic signed [31:0] comp_t;

	typedef struct {
		comp_t       rx, ry, rz;
		logic [30:0] dval;
		logic        eq;
		logic        flt;
	} vec_result_t;

	// Result store with the vector arithmetic predictor.
	class vec_scoreboard;
		vec_result_t pending[$];
		int          errors;

		// Saturate a signed wide value into the component range.
		function automatic comp_t clamp(input logic signed [127:0] v, ref logic flt);
			if (v > 128'sh7FFF_FFFF) begin
				flt = 1'b1;
				return 32'sh7FFF_FFFF;
			end
			if (v < -128'sh8000_0000) begin
				flt = 1'b1;
				return -32'sh8000_0000;
			end
			return v[31:0];
		endfunction

		// Truncating divide of signed magnitudes, then saturate.
		function automatic comp_t frac_div(input comp_t a, input comp_t b, ref logic flt);
			logic [127:0] ma, mb, q;
			logic         neg;
			ma = (a < 0) ? 128'(-64'(a)) : 128'(a);
			mb = (b < 0) ? 128'(-64'(b)) : 128'(b);
			if (mb == 0) begin
				flt = 1'b1;
				if (ma == 0)
					return '0;
				return (a < 0) ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
			end
			q = (ma << 16) / mb;
			neg = (a < 0) != (b < 0);
			return clamp(neg ? -$signed(q) : $signed(q), flt);
		endfunction

		function automatic logic [127:0] isqrt(input logic [127:0] n);
			logic [63:0]  r, c;
			r = '0;
			for (int k = 63; k >= 0; k--) begin
				c = r | (64'd1 << k);
				if (128'(c) * 128'(c) <= n)
					r = c;
			end
			return 128'(r);
		endfunction

		function automatic comp_t component_op(input logic [1:0] kind, input comp_t a,
				input comp_t b, ref logic flt);
			logic signed [127:0] wa, wb, p;
			wa = a;
			wb = b;
			case (kind)
				2'd0: return clamp(wa + wb, flt);
				2'd1: return clamp(wa - wb, flt);
				2'd2: begin
					p = wa * wb;
					// Truncate toward zero after the fraction shift.
					p = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
					return clamp(p, flt);
				end
				default: return frac_div(a, b, flt);
			endcase
		endfunction

		function void note_item(input logic [3:0] op, input comp_t ax, ay, az, bx, by, bz);
			vec_result_t  e;
			comp_t        av[3], bv[3];
			logic [127:0] sum, d, len;
			logic signed [127:0] df;
			logic         big;
			e = '{default: '0};
			av = '{ax, ay, az};
			bv = '{bx, by, bz};
			sum = '0;
			big = 1'b0;
			if (op <= OP_DIVS) begin
				e.rx = component_op(op[1:0], av[0], (op >= OP_ADDS) ? bx : bv[0], e.flt);
				e.ry = component_op(op[1:0], av[1], (op >= OP_ADDS) ? bx : bv[1], e.flt);
				e.rz = component_op(op[1:0], av[2], (op >= OP_ADDS) ? bx : bv[2], e.flt);
			end else if (op == OP_CMP) begin
				e.eq = (ax == bx) && (ay == by) && (az == bz);
			end else if (op == OP_DIST) begin
				for (int i = 0; i < 3; i++) begin
					df = 128'(av[i]) - 128'(bv[i]);
					if (df < 0)
						df = -df;
					if (df > 128'h7FFF_FFFF)
						big = 1'b1;
					else
						sum += df * df;
				end
				d = big ? 128'h8000_0000 : isqrt(sum);
				if (d > 128'h7FFF_FFFF) begin
					d = 128'h7FFF_FFFF;
					e.flt = 1'b1;
				end
				e.dval = d[30:0];
			end else if (op == OP_NORM) begin
				for (int i = 0; i < 3; i++)
					sum += 128'($signed(128'(av[i])) * $signed(128'(av[i])));
				len = isqrt(sum);
				if (len != 0) begin
					e.rx = frac_div(ax, comp_t'(len), e.flt);
					e.ry = frac_div(ay, comp_t'(len), e.flt);
					e.rz = frac_div(az, comp_t'(len), e.flt);
				end
			end
			// Length fits 32 bits unsigned but may exceed the signed range, so
			// normalisation divides by the full magnitude rather than comp_t.
			if (op == OP_NORM && len != 0 && len > 128'h7FFF_FFFF) begin
				e.flt = 1'b0;
				e.rx = norm_big(ax, len, e.flt);
				e.ry = norm_big(ay, len, e.flt);
				e.rz = norm_big(az, len, e.flt);
			end
			pending.push_back(e);
		endfunction

		function automatic comp_t norm_big(input comp_t a, input logic [127:0] l, ref logic flt);
			logic [127:0] ma, q;
			ma = (a < 0) ? 128'(-64'(a)) : 128'(a);
			q = (ma << 16) / l;
			return clamp((a < 0) ? -$signed(q) : $signed(q), flt);
		endfunction

		function void check_result(input vec_result_t got);
			vec_result_t e;
			if (pending.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.rx !== e.rx) begin
				$error("r_x expected %h got %h", e.rx, got.rx);
				errors++;
			end
			if (got.ry !== e.ry) begin
				$error("r_y expected %h got %h", e.ry, got.ry);
				errors++;
			end
			if (got.rz !== e.rz) begin
				$error("r_z expected %h got %h", e.rz, got.rz);
				errors++;
			end
			if (got.dval !== e.dval) begin
				$error("distance expected %h got %h", e.dval, got.dval);
				errors++;
			end
			if (got.eq !== e.eq) begin
				$error("equal_flag expected %b got %b", e.eq, got.eq);
				errors++;
			end
			if (got.flt !== e.flt) begin
				$error("fault expected %b got %b", e.flt, got.flt);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n, start, busy, done;
	logic [3:0]  operation;
	comp_t       a_x, a_y, a_z, b_x, b_y, b_z, r_x, r_y, r_z;
	logic [30:0] distance;
	logic        equal_flag, fault;
	int          idle_cycles = 0;

	vec_scoreboard sb;

	vector3_arithmetic_unit_core dut (.*);

	// Clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Results are checked at the rising edge that ends the strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{r_x, r_y, r_z, distance, equal_flag, fault});
	end

	// Watchdog on cycles with no accepted item or result.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic comp_t rand_comp();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return -32'sh8000_0000;
			2: return '0;
			3: return comp_t'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
			4: return comp_t'($urandom_range(0, 16)) <<< 16;
			default: return comp_t'($urandom);
		endcase
	endfunction

	// Present one item and hold it until accepted, then idle for a random gap.
	task automatic send_item(input logic [3:0] op, input comp_t ax, ay, az, bx, by, bz);
		int gap;
		start <= 1'b1;
		operation <= op;
		{a_x, a_y, a_z, b_x, b_y, b_z} <= {ax, ay, az, bx, by, bz};
		do
			@(posedge clk);
		while (busy);
		sb.note_item(op, ax, ay, az, bx, by, bz);
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3));
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin
		comp_t mx, mn, c;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		operation = '0;
		{a_x, a_y, a_z, b_x, b_y, b_z} = '0;
		mx = 32'sh7FFF_FFFF;
		mn = -32'sh8000_0000;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every operation at the extremes, division by zero both signs and 0/0,
		// zero-length normalisation, distance overflow and two unknown codes.
		for (int op = OP_ADD; op <= OP_NORM; op++)
			send_item(4'(op), mx, mn, 32'sh0001_8000, mx, mn, -32'sh0000_4000);
		send_item(OP_DIV, 32'sh0001_0000, -32'sh0001_0000, 0, 0, 0, 0);
		send_item(OP_DIVS, 32'sh0003_0000, -32'sh0003_0000, 0, 0, 5, 5);
		send_item(OP_NORM, 0, 0, 0, 1, 2, 3);
		send_item(OP_NORM, mn, mn, mn, 0, 0, 0);
		send_item(OP_DIST, mx, mx, mx, mn, mn, mn);
		send_item(OP_DIST, 32'sh0003_0000, 0, 0, 0, 32'sh0004_0000, 0);
		send_item(OP_CMP, 1, 2, 3, 1, 2, 3);
		send_item(OP_CMP, 1, 2, 3, 1, 2, 4);
		send_item(OP_MUL, mn, mx, -1, mn, mx, -1);
		send_item(OP_SUB, mn, mx, 0, mx, mn, 0);
		send_item(4'd11, 5, 6, 7, 8, 9, 10);
		send_item(4'd15, mx, mn, mx, mn, mx, mn);

		// Random items over codes 0 to 11, compares often made equal.
		for (int n = 0; n < 1430; n++) begin
			logic [3:0] op;
			comp_t      v[6];
			op = 4'($urandom_range(0, 15));
			if (op > 11)
				op = 4'($urandom_range(0, 10));
			foreach (v[i])
				v[i] = rand_comp();
			if (op == OP_CMP && $urandom_range(0, 1)) begin
				c = v[0];
				v[3] = v[0];
				v[4] = v[1];
				v[5] = ($urandom_range(0, 2) == 0) ? c ^ (32'sd1 << $urandom_range(0, 31))
					: v[2];
			end
			send_item(op, v[0], v[1], v[2], v[3], v[4], v[5]);
		end
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/vau_pkg.sv
hw/rtl/vau_mul.sv
hw/rtl/vau_sqrt.sv
hw/rtl/vau_div.sv
hw/rtl/vau_lane.sv
hw/rtl/vector3_arithmetic_unit_core.sv
hw/rtl/vau_checker.sv
bench/testbench.sv
